// ----- src/ready_pending_task_queue_unit_assert.svh -----
// Assertion macros for the ready / pending task queue.
// Included by files that check their own logic; no other dependencies.
`ifndef READY_PENDING_TASK_QUEUE_UNIT_ASSERT_SVH
`define READY_PENDING_TASK_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside reset
`define RPTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked during reset as well
`define RPTQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPTQ_ASSERT(label, prop, msg)
`define RPTQ_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- src/rptq_pkg.sv -----
// Shared types and constants of the ready / pending task queue.
// No dependencies.
`default_nettype none
package rptq_pkg;
  localparam int PEND_DEPTH = 64;
  localparam int RDY_DEPTH  = 64;
  localparam int PIDX_W = $clog2(PEND_DEPTH);
  localparam int RIDX_W = $clog2(RDY_DEPTH);
  localparam int PCNT_W = $clog2(PEND_DEPTH + 1);
  localparam int RCNT_W = $clog2(RDY_DEPTH + 1);
  localparam int NODE_W = 16;
  localparam int COST_W = 16;
  localparam int STAT_W = 3;
  localparam int COUNT_W = 7;
  localparam logic [PIDX_W:0] PEND_END = (PIDX_W + 1)'(PEND_DEPTH);
  localparam logic [RCNT_W-1:0] RDY_FULL = RCNT_W'(RDY_DEPTH);
  localparam logic [RIDX_W-1:0] RDY_LAST = RIDX_W'(RDY_DEPTH - 1);

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_PUSHED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_POP_READY = 3'd1;
  localparam logic [STAT_W-1:0] ST_POP_PEND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_PEND_FULL = 3'd4;
  localparam logic [STAT_W-1:0] ST_RDY_FULL  = 3'd5;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;
endpackage
`default_nettype wire

// ----- src/rptq_req_if.sv -----
// Request channel: operation, node id and cost with valid / ready.
// Depends on rptq_pkg.
`default_nettype none
interface rptq_req_if import rptq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [NODE_W-1:0] node_id;
  logic [COST_W-1:0] cost;
  modport source(output valid, operation, node_id, cost, input ready);
  modport sink(input valid, operation, node_id, cost, output ready);
endinterface
`default_nettype wire

// ----- src/rptq_rsp_if.sv -----
// Response channel: status, popped node and both fill counts.
// Depends on rptq_pkg.
`default_nettype none
interface rptq_rsp_if import rptq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [NODE_W-1:0]  popped_node;
  logic [COUNT_W-1:0] pending_count;
  logic [COUNT_W-1:0] ready_count;
  modport source(output valid, status, popped_node, pending_count, ready_count,
                 input ready);
  modport sink(input valid, status, popped_node, pending_count, ready_count,
               output ready);
endinterface
`default_nettype wire

// ----- src/rptq_ctrl.sv -----
// Controller: sequences accept, table scan, commit and response transfer.
// Depends on rptq_pkg.
`default_nettype none
module rptq_ctrl import rptq_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  wire  rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/rptq_dpath.sv -----
// Datapath: pending table and ready FIFO stores, scan unit, commit, response.
// Depends on rptq_pkg.
`default_nettype none
module rptq_dpath import rptq_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  wire                in_op,
  input  wire [NODE_W-1:0]   in_node,
  input  wire [COST_W-1:0]   in_cost,
  output logic [STAT_W-1:0]  out_status,
  output logic [NODE_W-1:0]  out_node,
  output logic [COUNT_W-1:0] out_pcount,
  output logic [COUNT_W-1:0] out_rcount
);
  // latched request
  logic              op_q;
  logic [NODE_W-1:0] node_q;
  logic [COST_W-1:0] cost_q;

  // stores
  logic [NODE_W-1:0] pnode_mem [PEND_DEPTH];
  logic [COST_W-1:0] pcost_mem [PEND_DEPTH];
  logic [NODE_W-1:0] rdy_mem   [RDY_DEPTH];
  logic [PEND_DEPTH-1:0] pvalid;
  logic [PCNT_W-1:0] pcount;
  logic [RIDX_W-1:0] rhead, rtail;
  logic [RCNT_W-1:0] rfill;
  logic [NODE_W-1:0] rdy_q;

  // scan
  logic [PIDX_W:0]   scan_addr;
  logic              rd_live;
  logic [PIDX_W-1:0] rd_idx;
  logic [NODE_W-1:0] rd_node;
  logic [COST_W-1:0] rd_cost;
  logic              hit, free_ok, best_ok;
  logic [PIDX_W-1:0] hit_slot, free_slot, best_slot;
  logic [COST_W-1:0] best_cost;
  logic [NODE_W-1:0] best_node;

  // commit decisions
  logic [STAT_W-1:0] st;
  logic [NODE_W-1:0] pop_node;
  logic              clr_en, set_en, wr_node_en, wr_cost_en, rpush, rpop;
  logic [PIDX_W-1:0] clr_slot, wr_slot;
  logic [PCNT_W-1:0] pcount_next;
  logic [RCNT_W-1:0] rfill_next;

  assign sts.scan_done = (scan_addr == PEND_END) && !rd_live;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      node_q <= in_node;
      cost_q <= in_cost;
    end
  end

  // scan address and registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_live   <= 1'b0;
    end else if (cmd.load) begin
      scan_addr <= '0;
      rd_live   <= 1'b0;
    end else if (cmd.scan && scan_addr != PEND_END) begin
      scan_addr <= scan_addr + 1'b1;
      rd_live   <= 1'b1;
    end else begin
      rd_live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= scan_addr[PIDX_W-1:0];
    rd_node <= pnode_mem[scan_addr[PIDX_W-1:0]];
    rd_cost <= pcost_mem[scan_addr[PIDX_W-1:0]];
    rdy_q   <= rdy_mem[rhead];
  end

  // match, first free and minimum cost, one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
      best_ok <= 1'b0;
    end else if (rd_live) begin
      if (pvalid[rd_idx] && rd_node == node_q && !hit) begin
        hit      <= 1'b1;
        hit_slot <= rd_idx;
      end
      if (!pvalid[rd_idx] && !free_ok) begin
        free_ok   <= 1'b1;
        free_slot <= rd_idx;
      end
      if (pvalid[rd_idx] && (!best_ok || rd_cost < best_cost)) begin
        best_ok   <= 1'b1;
        best_slot <= rd_idx;
        best_cost <= rd_cost;
        best_node <= rd_node;
      end
    end
  end

  // commit decision
  always_comb begin
    st         = ST_PUSHED;
    pop_node   = '0;
    clr_en     = 1'b0;
    clr_slot   = hit_slot;
    set_en     = 1'b0;
    wr_node_en = 1'b0;
    wr_cost_en = 1'b0;
    wr_slot    = free_slot;
    rpush      = 1'b0;
    rpop       = 1'b0;
    if (op_q == OP_PUSH) begin
      if (cost_q == '0) begin
        if (rfill == RDY_FULL) begin
          st = ST_RDY_FULL;
        end else begin
          clr_en = hit;
          rpush  = 1'b1;
        end
      end else if (hit) begin
        wr_cost_en = 1'b1;
        wr_slot    = hit_slot;
      end else if (free_ok) begin
        set_en     = 1'b1;
        wr_node_en = 1'b1;
        wr_cost_en = 1'b1;
      end else begin
        st = ST_PEND_FULL;
      end
    end else begin
      if (rfill != '0) begin
        rpop     = 1'b1;
        pop_node = rdy_q;
        st       = ST_POP_READY;
      end else if (best_ok) begin
        clr_en   = 1'b1;
        clr_slot = best_slot;
        pop_node = best_node;
        st       = ST_POP_PEND;
      end else begin
        st = ST_EMPTY;
      end
    end
    pcount_next = pcount + PCNT_W'(set_en) - PCNT_W'(clr_en);
    rfill_next  = rfill + RCNT_W'(rpush) - RCNT_W'(rpop);
  end

  // store writes
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_node_en) pnode_mem[wr_slot] <= node_q;
    if (cmd.exec && wr_cost_en) pcost_mem[wr_slot] <= cost_q;
    if (cmd.exec && rpush)      rdy_mem[rtail]     <= node_q;
  end

  // control state of both stores
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      pcount <= '0;
      rhead  <= '0;
      rtail  <= '0;
      rfill  <= '0;
    end else if (cmd.exec) begin
      if (clr_en) pvalid[clr_slot] <= 1'b0;
      if (set_en) pvalid[wr_slot]  <= 1'b1;
      pcount <= pcount_next;
      rfill  <= rfill_next;
      if (rpush) rtail <= (rtail == RDY_LAST) ? '0 : rtail + 1'b1;
      if (rpop)  rhead <= (rhead == RDY_LAST) ? '0 : rhead + 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= st;
      out_node   <= pop_node;
      out_pcount <= COUNT_W'(pcount_next);
      out_rcount <= COUNT_W'(rfill_next);
    end
  end
endmodule
`default_nettype wire

// ----- src/ready_pending_task_queue_unit.sv -----
// Top level of the ready / pending task queue.
// Depends on rptq_pkg, rptq_req_if, rptq_rsp_if, rptq_ctrl, rptq_dpath and the assert header.
`default_nettype none
`include "ready_pending_task_queue_unit_assert.svh"
// One request is handled at a time. Each request passes through the table
// scan, a commit and then the response, which waits for the response sink.
// During the scan the pending table memory is read one slot a cycle; the
// read is registered. The scan finds the node's slot, the first free slot
// and the lowest cost entry. The request channel is ready only when idle, so
// a new request is taken only after the previous response has transferred.
module ready_pending_task_queue_unit import rptq_pkg::*; (
  input wire         clk,
  input wire         rst,
  rptq_req_if.sink   req,
  rptq_rsp_if.source rsp
);
  cmd_t cmd;
  sts_t sts;

  rptq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rptq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (req.operation),
    .in_node    (req.node_id),
    .in_cost    (req.cost),
    .out_status (rsp.status),
    .out_node   (rsp.popped_node),
    .out_pcount (rsp.pending_count),
    .out_rcount (rsp.ready_count)
  );

  // one request in flight: never accepting while a response is offered
  `RPTQ_ASSERT(a_no_overlap, !(req.ready && rsp.valid), "ready while response pending")
  // a response transfer returns the block to idle
  `RPTQ_ASSERT(a_back_idle, (rsp.valid && rsp.ready) |=> req.ready, "not idle after response")
  // an accepted request blocks the next one
  `RPTQ_ASSERT(a_busy, (req.valid && req.ready) |=> (!req.ready && cmd.scan), "no scan")
  // reset leaves no response pending
  `RPTQ_ASSERT_RST(a_rst, rst |=> !rsp.valid, "response valid after reset")
endmodule
`default_nettype wire
